FILE: rtl/gcgs_pkg.sv
// ----------------------------------------------------------------------------
// gcgs_pkg
// Shared types, codes and helpers of the grade crossing gate sequencer.
// ----------------------------------------------------------------------------
package gcgs_pkg;

	// Width of the prewarn and gate motion frame counters.
	localparam int COUNT_BITS = 8;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Configuration port.
	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS  = 8;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PREWARN_TARGET = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MOTION_TIMEOUT = CFG_INDEX_BITS'(1);

	// Compare width: wide enough for a count plus one and for a register value.
	localparam int CMP_BITS = (COUNT_BITS + 1 > CFG_DATA_BITS) ? COUNT_BITS + 1 : CFG_DATA_BITS;

	typedef enum logic [2:0] {
		MODE_IDLE      = 3'd0,
		MODE_PREWARN   = 3'd1,
		MODE_LOWERING  = 3'd2,
		MODE_PROTECTED = 3'd3,
		MODE_RAISING   = 3'd4,
		MODE_FAULT     = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		CMD_UP    = 3'd0,
		CMD_WARN  = 3'd1,
		CMD_LOWER = 3'd2,
		CMD_HOLD  = 3'd3,
		CMD_RAISE = 3'd4,
		CMD_LATCH = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		FAULT_NONE    = 2'd0,
		FAULT_LAMP    = 2'd1,
		FAULT_TIMEOUT = 2'd2
	} fault_t;

	typedef enum logic [1:0] {
		ZONE_CLEAR    = 2'd0,
		ZONE_APPROACH = 2'd1,
		ZONE_ISLAND   = 2'd2
	} zone_t;

	typedef enum logic [1:0] {
		POS_MOVING = 2'd0,
		POS_UP     = 2'd1,
		POS_DOWN   = 2'd2,
		POS_BOTH   = 2'd3
	} pos_t;

	// One control frame as it sits in the input register.
	typedef struct packed {
		logic approach_track;
		logic island_track;
		logic gate_down_sense;
		logic gate_up_sense;
		logic lamp_good;
		logic clear_request;
	} frame_t;

	// Decoded view of the sensors.
	typedef struct packed {
		zone_t zone;
		pos_t  pos;
	} decode_t;

	// Configuration registers.
	typedef struct packed {
		logic [CFG_DATA_BITS-1:0] prewarn_target;
		logic [CFG_DATA_BITS-1:0] motion_timeout;
	} cfg_t;

	// One result item.
	typedef struct packed {
		mode_t  mode;
		cmd_t   gate_command;
		fault_t fault_code;
		zone_t  zone;
		pos_t   arm_position;
		logic   warning_on;
		logic   bell_on;
	} result_t;

	// Counter increment that stops at the top value.
	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_BITS'(1);
	endfunction

endpackage

FILE: rtl/grade_crossing_gate_sequencer.sv
// ----------------------------------------------------------------------------
// grade_crossing_gate_sequencer
// Level crossing gate sequencer: one control frame in, one result beat out.
// ----------------------------------------------------------------------------
// The block takes one frame beat per clock cycle and returns exactly one
// result beat for each frame: the frame lands in an input register, the
// mode state machine evaluates it in one pass of short logic, and the
// answer is caught in a result register while the mode, counters and fault
// cause are updated in the same edge. Throughput is set by that single
// state update per cycle, so a new frame is accepted every cycle as long as
// the result register can drain; a stalled output holds its beat steady and
// back-pressures the input only once the input register is also occupied.
// The prewarn_target and motion_timeout registers are written through the
// configuration channel, which is always ready; writes to indexes beyond
// those two are dropped.
// Write them only while no frame is in flight.
// ----------------------------------------------------------------------------
module grade_crossing_gate_sequencer import gcgs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,

	// Frame channel.
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      approach_track,
	input  logic                      island_track,
	input  logic                      gate_down_sense,
	input  logic                      gate_up_sense,
	input  logic                      lamp_good,
	input  logic                      clear_request,

	// Result channel.
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                mode,
	output logic [2:0]                gate_command,
	output logic [1:0]                fault_code,
	output logic [1:0]                zone,
	output logic [1:0]                arm_position,
	output logic                      warning_on,
	output logic                      bell_on,

	// Configuration write channel.
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	cfg_t    cfg_q;
	frame_t  frame_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	decode_t dec;
	result_t res;
	logic    advance;
	logic    in_take;

	// Configuration registers. The port never back-pressures.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prewarn_target <= CFG_DATA_BITS'(2);
			cfg_q.motion_timeout <= CFG_DATA_BITS'(8);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_PREWARN_TARGET) begin
				cfg_q.prewarn_target <= cfg_data;
			end else if (cfg_index == CFG_MOTION_TIMEOUT) begin
				cfg_q.motion_timeout <= cfg_data;
			end
		end
	end

	// The frame in the input register moves on whenever the result register
	// is empty or its beat is being taken this cycle.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			frame_s1.approach_track  <= approach_track;
			frame_s1.island_track    <= island_track;
			frame_s1.gate_down_sense <= gate_down_sense;
			frame_s1.gate_up_sense   <= gate_up_sense;
			frame_s1.lamp_good       <= lamp_good;
			frame_s1.clear_request   <= clear_request;
		end
	end

	gcgs_decode u_decode (
		.frame (frame_s1),
		.dec   (dec)
	);

	// State advances exactly once per frame, on the edge that moves it into
	// the result register.
	gcgs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.frame  (frame_s1),
		.dec    (dec),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign mode          = res_s2.mode;
	assign gate_command  = res_s2.gate_command;
	assign fault_code    = res_s2.fault_code;
	assign zone          = res_s2.zone;
	assign arm_position  = res_s2.arm_position;
	assign warning_on    = res_s2.warning_on;
	assign bell_on       = res_s2.bell_on;

endmodule

FILE: rtl/gcgs_decode.sv
// ----------------------------------------------------------------------------
// gcgs_decode
// Decodes track sensors into a zone and gate limit feedback into a position.
// ----------------------------------------------------------------------------
module gcgs_decode import gcgs_pkg::*; (
	input  frame_t  frame,
	output decode_t dec
);

	always_comb begin
		// The island circuit wins over the approach circuit.
		if (frame.island_track) begin
			dec.zone = ZONE_ISLAND;
		end else if (frame.approach_track) begin
			dec.zone = ZONE_APPROACH;
		end else begin
			dec.zone = ZONE_CLEAR;
		end

		unique case ({frame.gate_up_sense, frame.gate_down_sense})
			2'b11: dec.pos = POS_BOTH;
			2'b10: dec.pos = POS_UP;
			2'b01: dec.pos = POS_DOWN;
			default: dec.pos = POS_MOVING;
		endcase
	end

endmodule

FILE: rtl/gcgs_ctrl.sv
// ----------------------------------------------------------------------------
// gcgs_ctrl
// Mode state machine with its counters and latched fault cause.
// ----------------------------------------------------------------------------
module gcgs_ctrl import gcgs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  frame_t  frame,
	input  decode_t dec,
	input  cfg_t    cfg,
	output result_t res
);

	mode_t                 mode_q, mode_d;
	fault_t                held_q, held_d;
	logic [COUNT_BITS-1:0] pw_count_q, pw_count_d;
	logic [COUNT_BITS-1:0] mc_count_q, mc_count_d;
	logic                  clear;
	logic                  prewarn_done;
	logic                  motion_late;

	assign clear        = (dec.zone == ZONE_CLEAR);
	assign prewarn_done = (CMP_BITS'(pw_count_q) + CMP_BITS'(1)) >= CMP_BITS'(cfg.prewarn_target);
	assign motion_late  = CMP_BITS'(mc_count_q) >= CMP_BITS'(cfg.motion_timeout);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			held_q     <= FAULT_NONE;
			pw_count_q <= '0;
			mc_count_q <= '0;
		end else if (fire) begin
			mode_q     <= mode_d;
			held_q     <= held_d;
			pw_count_q <= pw_count_d;
			mc_count_q <= mc_count_d;
		end
	end

	always_comb begin
		mode_d           = mode_q;
		held_d           = held_q;
		pw_count_d       = pw_count_q;
		mc_count_d       = mc_count_q;
		res.gate_command = CMD_UP;
		res.fault_code   = FAULT_NONE;
		res.zone         = dec.zone;
		res.arm_position = dec.pos;
		res.warning_on   = 1'b0;
		res.bell_on      = 1'b0;

		priority if (mode_q == MODE_FAULT) begin
			if (frame.clear_request && clear && frame.lamp_good && dec.pos == POS_UP) begin
				mode_d = MODE_IDLE;
				held_d = FAULT_NONE;
			end else begin
				res.gate_command = CMD_LATCH;
				res.fault_code   = held_q;
				res.warning_on   = 1'b1;
				res.bell_on      = !clear;
			end
		end else if (!frame.lamp_good && (mode_q != MODE_IDLE || !clear)) begin
			mode_d           = MODE_FAULT;
			held_d           = FAULT_LAMP;
			pw_count_d       = '0;
			mc_count_d       = '0;
			res.gate_command = CMD_LATCH;
			res.fault_code   = FAULT_LAMP;
			res.warning_on   = 1'b1;
			res.bell_on      = 1'b1;
		end else begin
			unique case (mode_q)
				MODE_IDLE: begin
					if (!clear) begin
						mode_d           = MODE_PREWARN;
						pw_count_d       = COUNT_BITS'(1);
						res.gate_command = CMD_WARN;
						res.warning_on   = 1'b1;
						res.bell_on      = 1'b1;
					end
				end
				MODE_PREWARN: begin
					if (clear) begin
						mode_d     = MODE_IDLE;
						pw_count_d = '0;
					end else if (prewarn_done) begin
						mode_d           = MODE_LOWERING;
						mc_count_d       = COUNT_BITS'(1);
						res.gate_command = CMD_LOWER;
						res.warning_on   = 1'b1;
						res.bell_on      = 1'b1;
					end else begin
						pw_count_d       = sat_inc(pw_count_q);
						res.gate_command = CMD_WARN;
						res.warning_on   = 1'b1;
						res.bell_on      = 1'b1;
					end
				end
				MODE_LOWERING: begin
					if (dec.pos == POS_DOWN) begin
						mode_d           = MODE_PROTECTED;
						mc_count_d       = '0;
						res.gate_command = CMD_HOLD;
						res.warning_on   = 1'b1;
					end else if (motion_late) begin
						mode_d           = MODE_FAULT;
						held_d           = FAULT_TIMEOUT;
						pw_count_d       = '0;
						mc_count_d       = '0;
						res.gate_command = CMD_LATCH;
						res.fault_code   = FAULT_TIMEOUT;
						res.warning_on   = 1'b1;
						res.bell_on      = 1'b1;
					end else begin
						mc_count_d       = sat_inc(mc_count_q);
						res.gate_command = CMD_LOWER;
						res.warning_on   = 1'b1;
						res.bell_on      = 1'b1;
					end
				end
				MODE_PROTECTED: begin
					res.warning_on = 1'b1;
					if (clear) begin
						mode_d           = MODE_RAISING;
						mc_count_d       = COUNT_BITS'(1);
						res.gate_command = CMD_RAISE;
					end else begin
						res.gate_command = CMD_HOLD;
					end
				end
				MODE_RAISING: begin
					if (!clear) begin
						mode_d           = MODE_LOWERING;
						mc_count_d       = COUNT_BITS'(1);
						res.gate_command = CMD_LOWER;
						res.warning_on   = 1'b1;
						res.bell_on      = 1'b1;
					end else if (dec.pos == POS_UP) begin
						mode_d     = MODE_IDLE;
						mc_count_d = '0;
					end else if (motion_late) begin
						// The bell stays off when raising fails with the track clear.
						mode_d           = MODE_FAULT;
						held_d           = FAULT_TIMEOUT;
						pw_count_d       = '0;
						mc_count_d       = '0;
						res.gate_command = CMD_LATCH;
						res.fault_code   = FAULT_TIMEOUT;
						res.warning_on   = 1'b1;
					end else begin
						mc_count_d       = sat_inc(mc_count_q);
						res.gate_command = CMD_RAISE;
						res.warning_on   = 1'b1;
					end
				end
				default: begin
					// Unused mode codes latch the gate, report the held cause with lights and bell on, and keep their state.
					res.gate_command = CMD_LATCH;
					res.fault_code   = held_q;
					res.warning_on   = 1'b1;
					res.bell_on      = 1'b1;
				end
			endcase
		end

		res.mode = mode_d;
	end

endmodule

FILE: rtl/gcgs_checker.sv
// ----------------------------------------------------------------------------
// gcgs_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module gcgs_checker import gcgs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] mode,
	input logic [2:0] gate_command,
	input logic [1:0] fault_code,
	input logic       warning_on,
	input logic       bell_on
);

	// A stalled result beat stays and holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mode) && $stable(gate_command)
			&& $stable(fault_code) && $stable(warning_on) && $stable(bell_on))
		else $error("stalled result beat changed");

	// A fault code is only reported while the block sits in fault mode.
	a_fault_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault_code != FAULT_NONE |-> mode == MODE_FAULT)
		else $error("fault code outside fault mode");

	// Fault mode always commands the latch and keeps the lights flashing.
	a_fault_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode == MODE_FAULT |-> gate_command == CMD_LATCH && warning_on)
		else $error("fault mode without latch command and warning");

	// Idle means gate up with lights and bell dark.
	a_idle_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode == MODE_IDLE |-> gate_command == CMD_UP && !warning_on && !bell_on)
		else $error("idle result drives warning or a gate command");

endmodule

bind grade_crossing_gate_sequencer gcgs_checker u_gcgs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.mode         (mode),
	.gate_command (gate_command),
	.fault_code   (fault_code),
	.warning_on   (warning_on),
	.bell_on      (bell_on)
);
